FILE: sv/pds_pkg.sv
// Package for the PLL divider search unit: command/status structs, search limits,
// reciprocal constants for the reference divider. No dependencies.
`default_nettype none
package pds_pkg;

    localparam int unsigned CLK_W    = 22;   // pixel clock field
    localparam int unsigned TOL_W    = 16;   // tolerance register
    localparam int unsigned REF_W    = 18;   // reference clock register
    localparam int unsigned CFG_W    = 18;   // widest register
    localparam int unsigned RD_W     = 3;
    localparam int unsigned LM_W     = 8;
    localparam int unsigned PROD_W   = REF_W + LM_W;     // ref_clock * multiplier
    localparam int unsigned RECIP_W  = 27;
    localparam int unsigned RECIP_SH = 28;
    localparam int unsigned VCO_W    = PROD_W + RECIP_W - RECIP_SH;

    localparam logic [RD_W-1:0] RD_FIRST = 3'd3;
    localparam logic [RD_W-1:0] RD_LAST  = 3'd5;
    localparam int unsigned LM_MIN_PER_REF = 12;
    localparam int unsigned LM_MAX_PER_REF = 32;

    // register indexes of the configuration port
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_REF_CLOCK = 1'b1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1000;
    localparam logic [REF_W-1:0] REF_RESET = 18'd100000;

    typedef struct packed {
        logic            start;    // load pixel clock, target = clock * 1
        logic            next_pd;  // target += clock
        logic            issue;    // launch one trial
        logic            flush;    // drop trials in flight
        logic [RD_W-1:0] rd;
        logic [LM_W-1:0] lm;
    } t_cmd;

    typedef struct packed {
        logic            hit;      // oldest trial in flight matched
        logic            busy;     // trials still in flight
        logic [RD_W-1:0] rd;
        logic [LM_W-1:0] lm;
    } t_status;

    // first and last multiplier allowed for a reference divider
    function automatic logic [LM_W-1:0] f_lm_first(input logic [RD_W-1:0] rd);
        f_lm_first = LM_W'(LM_MIN_PER_REF * rd);
    endfunction

    function automatic logic [LM_W-1:0] f_lm_last(input logic [RD_W-1:0] rd);
        f_lm_last = LM_W'(LM_MAX_PER_REF * rd);
    endfunction

    // ceil(2^RECIP_SH / rd); exact floor division for products below 2^26
    function automatic logic [RECIP_W-1:0] f_recip(input logic [RD_W-1:0] rd);
        logic [RECIP_W-1:0] m;
        case (rd)
            3'd3:    m = 27'd89478486;
            3'd4:    m = 27'd67108864;
            3'd5:    m = 27'd53687092;
            default: m = '0;
        endcase
        f_recip = m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/pds_datapath.sv
// Datapath of the PLL divider search: configuration registers, target accumulator
// and a three-stage trial pipeline. Depends on pds_pkg.
`default_nettype none
module pds_datapath #(
    parameter int unsigned PD_W = 6
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_addr,
    input  wire [pds_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire [pds_pkg::CLK_W-1:0]      i_pix_clk,
    input  wire [PD_W-1:0]                i_pd,
    input  pds_pkg::t_cmd                 i_cmd,
    output pds_pkg::t_status              o_status,
    output logic [PD_W-1:0]               o_hit_pd
);

    localparam int unsigned TGT_W = pds_pkg::CLK_W + PD_W;

    logic [pds_pkg::TOL_W-1:0] r_tol;
    logic [pds_pkg::REF_W-1:0] r_ref;
    logic [pds_pkg::CLK_W-1:0] r_pix;
    logic [TGT_W-1:0]          r_tgt;

    // stage 1: ref * lm
    logic                        r_v1;
    logic [pds_pkg::PROD_W-1:0]  r_prod1;
    logic [TGT_W-1:0]            r_tgt1;
    logic [pds_pkg::RD_W-1:0]    r_rd1;
    logic [pds_pkg::LM_W-1:0]    r_lm1;
    logic [PD_W-1:0]             r_pd1;
    // stage 2: vco = floor(prod / rd)
    logic                        r_v2;
    logic [pds_pkg::VCO_W-1:0]   r_vco2;
    logic [TGT_W-1:0]            r_tgt2;
    logic [pds_pkg::RD_W-1:0]    r_rd2;
    logic [pds_pkg::LM_W-1:0]    r_lm2;
    logic [PD_W-1:0]             r_pd2;
    // stage 3: match flag
    logic                        r_hit3;
    logic [pds_pkg::RD_W-1:0]    r_rd3;
    logic [pds_pkg::LM_W-1:0]    r_lm3;
    logic [PD_W-1:0]             r_pd3;

    logic [pds_pkg::PROD_W+pds_pkg::RECIP_W-1:0] w_scaled;
    logic [TGT_W-1:0]                            w_vco;
    logic [TGT_W-1:0]                            w_err;
    logic                                        w_match;

    assign w_scaled = pds_pkg::PROD_W'(r_prod1) * pds_pkg::f_recip(r_rd1);
    assign w_vco    = TGT_W'(r_vco2);
    assign w_err    = (r_tgt2 > w_vco) ? (r_tgt2 - w_vco) : (w_vco - r_tgt2);
    assign w_match  = w_err < TGT_W'(r_tol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= pds_pkg::TOL_RESET;
            r_ref  <= pds_pkg::REF_RESET;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_hit3 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pds_pkg::CFG_TOLERANCE: r_tol <= i_cfg_wdata[pds_pkg::TOL_W-1:0];
                    pds_pkg::CFG_REF_CLOCK: r_ref <= i_cfg_wdata[pds_pkg::REF_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.flush || i_cmd.start) begin
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
                r_hit3 <= 1'b0;
            end else begin
                r_v1   <= i_cmd.issue;
                r_v2   <= r_v1;
                r_hit3 <= r_v2 && w_match;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pix <= i_pix_clk;
            r_tgt <= TGT_W'(i_pix_clk);
        end else if (i_cmd.next_pd) begin
            r_tgt <= r_tgt + TGT_W'(r_pix);
        end
        r_prod1 <= pds_pkg::PROD_W'(r_ref) * pds_pkg::PROD_W'(i_cmd.lm);
        r_tgt1  <= r_tgt;
        r_rd1   <= i_cmd.rd;
        r_lm1   <= i_cmd.lm;
        r_pd1   <= i_pd;
        r_vco2  <= w_scaled[pds_pkg::RECIP_SH +: pds_pkg::VCO_W];
        r_tgt2  <= r_tgt1;
        r_rd2   <= r_rd1;
        r_lm2   <= r_lm1;
        r_pd2   <= r_pd1;
        r_rd3   <= r_rd2;
        r_lm3   <= r_lm2;
        r_pd3   <= r_pd2;
    end

    assign o_status.hit  = r_hit3;
    assign o_status.busy = r_v1 | r_v2 | r_hit3;
    assign o_status.rd   = r_rd3;
    assign o_status.lm   = r_lm3;
    assign o_hit_pd      = r_pd3;

endmodule
`default_nettype wire

FILE: sv/pds_ctrl.sv
// Controller of the PLL divider search: walks post divider, reference divider and
// multiplier, catches the first hit and holds the output beat. Depends on pds_pkg.
`default_nettype none
module pds_ctrl #(
    parameter int unsigned PD_W    = 6,
    parameter int unsigned PD_LAST = 63
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output logic [23:0]          o_out_data,
    output pds_pkg::t_cmd        o_cmd,
    output logic [PD_W-1:0]      o_pd,
    input  pds_pkg::t_status     i_status,
    input  wire [PD_W-1:0]       i_hit_pd
);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DRAIN, ST_FINISH} t_state;

    localparam logic [PD_W-1:0] PD_END = PD_W'(PD_LAST);

    t_state                    r_state, n_state;
    logic [PD_W-1:0]           r_pd, n_pd;
    logic [pds_pkg::RD_W-1:0]  r_rd, n_rd;
    logic [pds_pkg::LM_W-1:0]  r_lm, n_lm;
    logic                      r_found, n_found;
    logic [PD_W-1:0]           r_res_pd, n_res_pd;
    logic [pds_pkg::RD_W-1:0]  r_res_rd, n_res_rd;
    logic [pds_pkg::LM_W-1:0]  r_res_lm, n_res_lm;
    logic                      r_out_valid, n_out_valid;
    logic [23:0]               r_out_data, n_out_data;
    logic [pds_pkg::RD_W-1:0]  w_rd_inc;

    assign w_rd_inc = r_rd + 3'd1;

    always_comb begin
        n_state     = r_state;
        n_pd        = r_pd;
        n_rd        = r_rd;
        n_lm        = r_lm;
        n_found     = r_found;
        n_res_pd    = r_res_pd;
        n_res_rd    = r_res_rd;
        n_res_lm    = r_res_lm;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_cmd       = '0;
        o_cmd.rd    = r_rd;
        o_cmd.lm    = r_lm;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_pd    = PD_W'(1);
                    n_rd    = pds_pkg::RD_FIRST;
                    n_lm    = pds_pkg::f_lm_first(pds_pkg::RD_FIRST);
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.hit) begin
                    // oldest trial matched: drop the younger ones
                    o_cmd.flush = 1'b1;
                    n_found  = 1'b1;
                    n_res_pd = i_hit_pd;
                    n_res_rd = i_status.rd;
                    n_res_lm = i_status.lm;
                    n_state  = ST_FINISH;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (r_lm == pds_pkg::f_lm_last(r_rd)) begin
                        if (r_rd == pds_pkg::RD_LAST) begin
                            if (r_pd == PD_END) begin
                                n_state = ST_DRAIN;
                            end else begin
                                o_cmd.next_pd = 1'b1;
                                n_pd = r_pd + PD_W'(1);
                                n_rd = pds_pkg::RD_FIRST;
                                n_lm = pds_pkg::f_lm_first(pds_pkg::RD_FIRST);
                            end
                        end else begin
                            n_rd = w_rd_inc;
                            n_lm = pds_pkg::f_lm_first(w_rd_inc);
                        end
                    end else begin
                        n_lm = r_lm + 8'd1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_status.hit) begin
                    o_cmd.flush = 1'b1;
                    n_found  = 1'b1;
                    n_res_pd = i_hit_pd;
                    n_res_rd = i_status.rd;
                    n_res_lm = i_status.lm;
                    n_state  = ST_FINISH;
                end else if (!i_status.busy) begin
                    n_found  = 1'b0;
                    n_res_pd = '0;
                    n_res_rd = '0;
                    n_res_lm = '0;
                    n_state  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {6'd0, r_res_rd, r_res_lm, r_res_pd[5:0], r_found};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pd       <= n_pd;
        r_rd       <= n_rd;
        r_lm       <= n_lm;
        r_found    <= n_found;
        r_res_pd   <= n_res_pd;
        r_res_rd   <= n_res_rd;
        r_res_lm   <= n_res_lm;
        r_out_data <= n_out_data;
    end

    // hold off request beats while in reset
    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_pd        = r_pd;

endmodule
`default_nettype wire

FILE: sv/pll_divider_search_unit.sv
// Top level of the PLL divider search unit: controller plus trial datapath.
// Depends on pds_pkg, pds_ctrl and pds_datapath.
// Usage:
//   Slave beat (i_s_*): one requested pixel clock in kHz. Master beat (o_m_*):
//   found flag, post divider, loop multiplier and reference divider of the first
//   setting whose VCO lies strictly within the tolerance of clock * post divider,
//   all zero when none does.
//   Configuration: write tolerance_khz (index 0) or ref_clock_khz (index 1) with
//   i_cfg_we high for one cycle; write only while no search is running.
//   The search walks post divider 1..POST_DIV_LIMIT-1, reference divider 3..5 and
//   the allowed multipliers 12*rd..32*rd, one trial per cycle through a
//   three-stage pipeline (multiply, reciprocal divide, compare): 243 trials per
//   post divider. A hit ends the search early; with no hit every post divider
//   is tried and the pipeline drains before the all-zero result is loaded. One
//   item is searched at a time; the next input beat can be taken in the cycle
//   after the result is loaded.
//   The result sits in an output register; while it waits for i_m_tready the
//   block already takes the next input beat and searches, and holds the second
//   result until the register frees. Reset restores the register defaults
//   (1000 kHz, 100000 kHz) and drops any search and pending result.
`default_nettype none
module pll_divider_search_unit #(
    parameter int unsigned POST_DIV_LIMIT = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire         i_cfg_addr,
    input  wire [17:0]  i_cfg_wdata,
    // request channel
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [23:0]  i_s_tdata,   // [21:0] pixel_clock_khz, [23:22] zero
    // result channel
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata    // [0] found, [6:1] post_divider,
                                     // [14:7] loop_multiplier, [17:15] ref_divider
);

    // post divider counter: wide enough for the limit, never narrower than the field
    localparam int unsigned PD_BITS = $clog2(POST_DIV_LIMIT);
    localparam int unsigned PD_W    = (PD_BITS > 6) ? PD_BITS : 6;

    pds_pkg::t_cmd    w_cmd;
    pds_pkg::t_status w_status;
    logic [PD_W-1:0]  w_pd;
    logic [PD_W-1:0]  w_hit_pd;

    pds_ctrl #(
        .PD_W    (PD_W),
        .PD_LAST (POST_DIV_LIMIT - 1)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_cmd       (w_cmd),
        .o_pd        (w_pd),
        .i_status    (w_status),
        .i_hit_pd    (w_hit_pd)
    );

    pds_datapath #(
        .PD_W (PD_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix_clk   (i_s_tdata[pds_pkg::CLK_W-1:0]),
        .i_pd        (w_pd),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_hit_pd    (w_hit_pd)
    );

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for pll_divider_search_unit: directed table, then random pixel clocks
// under four sender/receiver idling mixes, each result checked against a typed or searched set.
// Depends on pds_pkg and pll_divider_search_unit.
`default_nettype none
module testbench;

    localparam int          PD_LIMIT     = 64;          // post divider runs 1..PD_LIMIT-1
    localparam int          MULT_LO      = 24;          // outer bounds of the multiplier sweep
    localparam int          MULT_HI      = 160;
    localparam int unsigned CYCLE_LIMIT  = 20_000_000;  // hang guard, well above a full-miss run
    localparam int          RANDOM_BEATS = 20;          // per idling phase
    localparam logic [pds_pkg::CLK_W-1:0] PIX_MAX = {pds_pkg::CLK_W{1'b1}};

    // result beat fields, lowest bit last so the struct maps straight onto o_m_tdata[17:0]
    typedef struct packed {
        logic [pds_pkg::RD_W-1:0] ref_div;
        logic [pds_pkg::LM_W-1:0] loop_mult;
        logic [5:0]               post_div;
        logic                     found;
    } t_divider_set;

    // one line of the directed table: optional register writes, then one request beat
    typedef struct packed {
        logic                      set_tol;
        logic [pds_pkg::TOL_W-1:0] tol;
        logic                      set_ref;
        logic [pds_pkg::REF_W-1:0] refclk;
        logic [pds_pkg::CLK_W-1:0] pix;
        logic                      typed;   // want is typed in; otherwise predict it
        t_divider_set              want;
    } t_dir_row;

    localparam t_divider_set MISS      = '0;
    // post divider 1, first trial of the sweep
    localparam t_divider_set FIRST_TRY = '{ref_div: 3'd3, loop_mult: 8'd36,
                                           post_div: 6'd1, found: 1'b1};
    // post divider 1, last multiplier allowed for reference divider 3
    localparam t_divider_set TOP_RD3   = '{ref_div: 3'd3, loop_mult: 8'd96,
                                           post_div: 6'd1, found: 1'b1};

    localparam int N_DIRECTED = 19;
    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        // reset registers: 1000 kHz tolerance, 100000 kHz reference
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd0,       1'b1, MISS},       // zero clock never reaches VCO
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd3200000, 1'b1, TOP_RD3},    // exact top of rd 3 range
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd1200000, 1'b1, FIRST_TRY},  // exact lowest VCO
        '{1'b0, 16'd0, 1'b0, 18'd0, PIX_MAX,     1'b1, MISS},       // above every VCO
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd1200999, 1'b1, FIRST_TRY},  // error one below tolerance
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd1201000, 1'b0, MISS},       // error equal to tolerance
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd100000,  1'b0, MISS},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'h200000,  1'b0, MISS},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'h155555,  1'b0, MISS},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'h2AAAAA,  1'b0, MISS},
        // zero tolerance: nothing can match, even an exact VCO
        '{1'b1, 16'd0, 1'b0, 18'd0, 22'd1200000, 1'b1, MISS},
        // both registers at their top
        '{1'b1, 16'hFFFF, 1'b1, 18'h3FFFF, 22'd3145716, 1'b1, FIRST_TRY},
        '{1'b0, 16'd0,    1'b0, 18'd0,     PIX_MAX,     1'b0, MISS},
        // zero reference clock: every VCO is zero, error is the target itself
        '{1'b0, 16'd0, 1'b1, 18'd0, 22'd0,     1'b1, FIRST_TRY},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd65534, 1'b1, FIRST_TRY},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd65535, 1'b1, MISS},
        // tightest nonzero setting: tolerance 1, reference 1 kHz
        '{1'b1, 16'd1, 1'b1, 18'd1, 22'd12, 1'b1, FIRST_TRY},
        '{1'b0, 16'd0, 1'b0, 18'd0, 22'd5,  1'b0, MISS},
        // back to the reset values
        '{1'b1, 16'd1000, 1'b1, 18'd100000, 22'd1234567, 1'b0, MISS}
    };

    // per idling phase: chance in percent that the sender idles / the receiver stalls
    localparam int GAP_PCT   [4] = '{0, 49, 0, 27};
    localparam int STALL_PCT [4] = '{0, 0, 49, 27};

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic                        i_cfg_addr  = 1'b0;
    logic [pds_pkg::CFG_W-1:0]   i_cfg_wdata = '0;
    logic                        i_s_tvalid  = 1'b0;
    logic                        o_s_tready;
    logic [23:0]                 i_s_tdata   = '0;    // [21:0] pixel_clock_khz, [23:22] zero
    logic                        o_m_tvalid;
    logic                        i_m_tready  = 1'b0;
    logic [23:0]                 o_m_tdata;           // [0] found, [6:1] post_divider,
                                                      // [14:7] loop_multiplier, [17:15] ref_divider

    // bench copy of the two registers, kept in step with every write
    logic [pds_pkg::TOL_W-1:0]   tol_khz;
    logic [pds_pkg::REF_W-1:0]   refclk_khz;

    t_divider_set       pending_settings [$];   // expected results, oldest first
    t_divider_set       got_set;
    t_divider_set       want_set;
    int                 gap_pct     = 0;
    int                 stall_pct   = 0;
    int unsigned        cycle_count = 0;
    int unsigned        mismatches  = 0;
    int unsigned        beats_sent  = 0;
    int unsigned        results_checked = 0;
    int unsigned        found_sent  = 0;
    int unsigned        settings_used = 1;

    pll_divider_search_unit #(
        .POST_DIV_LIMIT (PD_LIMIT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // First setting in search order whose VCO lies strictly within tolerance of
    // clock * post divider; all zero when the sweep runs out.
    function automatic t_divider_set search_dividers(input logic [pds_pkg::CLK_W-1:0] pix);
        t_divider_set      r;
        longint unsigned   target;
        longint unsigned   vco;
        longint unsigned   err;
        int                lm_lo;
        int                lm_hi;
        r = MISS;
        for (int pd = 1; pd < PD_LIMIT; pd++) begin
            target = 64'(pix) * 64'(pd);
            for (int rd = int'(pds_pkg::RD_FIRST); rd <= int'(pds_pkg::RD_LAST); rd++) begin
                // skip multipliers outside 12..32 times the reference divider
                lm_lo = (pds_pkg::LM_MIN_PER_REF * rd > MULT_LO) ?
                        pds_pkg::LM_MIN_PER_REF * rd : MULT_LO;
                lm_hi = (pds_pkg::LM_MAX_PER_REF * rd < MULT_HI) ?
                        pds_pkg::LM_MAX_PER_REF * rd : MULT_HI;
                for (int lm = lm_lo; lm <= lm_hi; lm++) begin
                    vco = 64'(refclk_khz) * 64'(lm) / 64'(rd);
                    err = (target > vco) ? target - vco : vco - target;
                    if (err < 64'(tol_khz)) begin
                        r.found     = 1'b1;
                        r.post_div  = 6'(pd);
                        r.loop_mult = pds_pkg::LM_W'(lm);
                        r.ref_div   = pds_pkg::RD_W'(rd);
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    // Aim a clock at a random allowed setting with a small post divider, landing
    // inside, on or just past the tolerance edge, so most searches end early.
    function automatic logic [pds_pkg::CLK_W-1:0] aim_at_setting();
        int unsigned rd;
        int unsigned lm;
        int unsigned pd;
        longint      vco;
        longint      off;
        longint      span;
        longint      pix;
        rd   = $urandom_range(pds_pkg::RD_LAST, pds_pkg::RD_FIRST);
        lm   = $urandom_range(pds_pkg::LM_MAX_PER_REF * rd, pds_pkg::LM_MIN_PER_REF * rd);
        pd   = $urandom_range(6, 1);
        vco  = longint'(refclk_khz) * lm / rd;
        span = longint'(tol_khz);
        case ($urandom_range(3, 0))
            0: off = span;                    // offset equal to tolerance
            1: off = (span > 0) ? 1 - span : 0;
            default: off = longint'($urandom_range(2 * span, 0)) - span;
        endcase
        pix = (vco + off) / pd;
        if (pix < 0)
            pix = 0;
        if (pix > longint'(PIX_MAX))
            pix = longint'(PIX_MAX);
        return pds_pkg::CLK_W'(pix);
    endfunction

    // Drive one register write and mirror it in the bench copy.
    task automatic write_register(input logic addr, input logic [pds_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        if (addr == pds_pkg::CFG_TOLERANCE)
            tol_khz = data[pds_pkg::TOL_W-1:0];
        else
            refclk_khz = data[pds_pkg::REF_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, then hold until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_settings.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Offer one request beat after random idle cycles; record what it must return.
    task automatic send_pixel_clock(input logic [pds_pkg::CLK_W-1:0] pix,
                                    input t_divider_set want);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, pix};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pending_settings.push_back(want);
        beats_sent++;
        if (want.found)
            found_sent++;
    endtask

    // Receiver: stall at random per the current phase.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Result checker: compare each accepted beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_set = t_divider_set'(o_m_tdata[17:0]);
            results_checked++;
            if (pending_settings.size() == 0) begin
                $error("result beat %h arrived with no request outstanding", o_m_tdata);
                mismatches++;
            end else begin
                want_set = pending_settings.pop_front();
                if (got_set.found !== want_set.found) begin
                    $error("found: expected %0d, got %0d", want_set.found, got_set.found);
                    mismatches++;
                end
                if (got_set.post_div !== want_set.post_div) begin
                    $error("post_divider: expected %0d, got %0d",
                           want_set.post_div, got_set.post_div);
                    mismatches++;
                end
                if (got_set.loop_mult !== want_set.loop_mult) begin
                    $error("loop_multiplier: expected %0d, got %0d",
                           want_set.loop_mult, got_set.loop_mult);
                    mismatches++;
                end
                if (got_set.ref_div !== want_set.ref_div) begin
                    $error("ref_divider: expected %0d, got %0d",
                           want_set.ref_div, got_set.ref_div);
                    mismatches++;
                end
            end
        end
    end

    // Hang guard: the limit lies well above any full-miss search, so this only trips on a stall.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_settings.size());
            $display("pll_divider_search_unit verification failed");
            $finish;
        end
    end

    initial begin
        t_dir_row                  row;
        t_divider_set              want;
        logic [pds_pkg::CLK_W-1:0] pix;
        int unsigned               random_sent;

        tol_khz     = pds_pkg::TOL_RESET;
        refclk_khz  = pds_pkg::REF_RESET;
        random_sent = 0;

        // hold reset at the start, then release it for good
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling on either side
        for (int n = 0; n < N_DIRECTED; n++) begin
            row = DIRECTED_ROWS[n];
            if (row.set_tol || row.set_ref) begin
                drain_results();
                if (row.set_tol)
                    write_register(pds_pkg::CFG_TOLERANCE, pds_pkg::CFG_W'(row.tol));
                if (row.set_ref)
                    write_register(pds_pkg::CFG_REF_CLOCK, row.refclk);
                settings_used++;
            end
            want = row.typed ? row.want : search_dividers(row.pix);
            send_pixel_clock(row.pix, want);
        end

        // random requests: one register setting and one idling mix per phase
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            if ($urandom_range(1, 0))
                write_register(pds_pkg::CFG_TOLERANCE,
                               pds_pkg::CFG_W'($urandom_range(4000, 1)));
            else
                write_register(pds_pkg::CFG_TOLERANCE,
                               pds_pkg::CFG_W'($urandom_range(65535, 1)));
            write_register(pds_pkg::CFG_REF_CLOCK, pds_pkg::CFG_W'($urandom_range(262143, 1)));
            settings_used++;
            gap_pct   = GAP_PCT[ph];
            stall_pct = STALL_PCT[ph];
            for (int k = 0; k < RANDOM_BEATS; k++) begin
                // mostly clocks aimed at a setting; the rest anywhere in the field
                if ($urandom_range(99, 0) < 85)
                    pix = aim_at_setting();
                else
                    pix = pds_pkg::CLK_W'($urandom);
                send_pixel_clock(pix, search_dividers(pix));
                random_sent++;
            end
        end

        // let the last results out, then allow for the pipeline tail
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d pixel clock beats (%0d directed, %0d random) over %0d settings.",
                 beats_sent, N_DIRECTED, random_sent, settings_used);
        $display("Checked %0d result beats, %0d expected with a divider set found.",
                 results_checked, found_sent);
        if (mismatches == 0 && pending_settings.size() == 0) begin
            $display("pll_divider_search_unit verification clean");
        end else begin
            $display("pll_divider_search_unit verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
sv/pds_pkg.sv
sv/pds_datapath.sv
sv/pds_ctrl.sv
sv/pll_divider_search_unit.sv
tb/sv/testbench.sv
